/* rtl/gcrsnd_pkg.sv */
// Package for the 6-and-2 GCR sector nibble decoder.
// Holds the parse phases, result kinds, marks, lookup tables and small helpers.
// No dependencies.
package gcrsnd_pkg;

	localparam int SecondaryCount = 86;
	localparam int SectorBytes    = 256;
	localparam int SectorNibbles  = SecondaryCount + SectorBytes;

	// parse phases; codes 20..31 are unused and behave as the address prolog scan
	typedef enum logic [4:0] {
		PhScanA = 5'd0,
		PhA2    = 5'd1,
		PhA3    = 5'd2,
		PhVolH  = 5'd3,
		PhVolL  = 5'd4,
		PhTrkH  = 5'd5,
		PhTrkL  = 5'd6,
		PhSecH  = 5'd7,
		PhSecL  = 5'd8,
		PhCkH   = 5'd9,
		PhCkL   = 5'd10,
		PhAep1  = 5'd11,
		PhAep2  = 5'd12,
		PhScanD = 5'd13,
		PhD2    = 5'd14,
		PhD3    = 5'd15,
		PhData  = 5'd16,
		PhScanE = 5'd17,
		PhE2    = 5'd18,
		PhE3    = 5'd19
	} phase_t;

	typedef enum logic [1:0] {
		KindData     = 2'd0,
		KindSectorOk = 2'd1,
		KindCkBad    = 2'd2,
		KindAbort    = 2'd3
	} kind_t;

	localparam logic [7:0] MarkD5 = 8'hD5;
	localparam logic [7:0] MarkAA = 8'hAA;
	localparam logic [7:0] Mark96 = 8'h96;
	localparam logic [7:0] MarkAD = 8'hAD;
	localparam logic [7:0] MarkDE = 8'hDE;
	localparam logic [7:0] MarkEB = 8'hEB;

	localparam logic [7:0] PairHiMask = 8'hAA;
	localparam logic [7:0] PairLoMask = 8'h55;

	localparam logic [7:0] TrackLimitReset = 8'd35;

	localparam logic [7:0] GcrCodes [64] = '{
		8'h96, 8'h97, 8'h9a, 8'h9b, 8'h9d, 8'h9e, 8'h9f, 8'ha6,
		8'ha7, 8'hab, 8'hac, 8'had, 8'hae, 8'haf, 8'hb2, 8'hb3,
		8'hb4, 8'hb5, 8'hb6, 8'hb7, 8'hb9, 8'hba, 8'hbb, 8'hbc,
		8'hbd, 8'hbe, 8'hbf, 8'hcb, 8'hcd, 8'hce, 8'hcf, 8'hd3,
		8'hd6, 8'hd7, 8'hd9, 8'hda, 8'hdb, 8'hdc, 8'hdd, 8'hde,
		8'hdf, 8'he5, 8'he6, 8'he7, 8'he9, 8'hea, 8'heb, 8'hec,
		8'hed, 8'hee, 8'hef, 8'hf2, 8'hf3, 8'hf4, 8'hf5, 8'hf6,
		8'hf7, 8'hf9, 8'hfa, 8'hfb, 8'hfc, 8'hfd, 8'hfe, 8'hff
	};

	localparam logic [3:0] SectorMap [16] = '{
		4'h0, 4'h7, 4'hE, 4'h6, 4'hD, 4'h5, 4'hC, 4'h4,
		4'hB, 4'h3, 4'hA, 4'h2, 4'h9, 4'h1, 4'h8, 4'hF
	};

	typedef struct packed {
		logic       hit;
		logic [5:0] value;
	} gcr_lookup_t;

	// control from the parser to the secondary chain
	typedef struct packed {
		logic shift;  // move every cell one place toward the head
		logic fill;   // tail takes new value (else the head wraps around)
	} chain_ctl_t;

	function automatic gcr_lookup_t gcr_lookup(input logic [7:0] nb);
		gcr_lookup_t r;
		r = '0;
		for (int k = 0; k < 64; k++) begin
			if (GcrCodes[k] == nb) begin
				r.hit   = 1'b1;
				r.value = 6'(k);
			end
		end
		return r;
	endfunction

	// 4-and-4: odd bits from the first nibble, even bits from the second
	function automatic logic [7:0] pair_decode(input logic [7:0] hi, input logic [7:0] lo);
		return ({hi[6:0], 1'b0} & PairHiMask) | (lo & PairLoMask);
	endfunction

endpackage

/* rtl/gcrsnd_if.sv */
// Handshake channels of the GCR sector nibble decoder: nibble input,
// result output and track limit write. Depends on nothing.
interface gcrsnd_nib_if;
	logic       valid;
	logic       ready;
	logic [7:0] nibble;

	modport source (output valid, output nibble, input ready);
	modport sink (input valid, input nibble, output ready);
endinterface

interface gcrsnd_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [7:0] data_byte;
	logic [7:0] byte_index;
	logic [7:0] track_number;
	logic [3:0] logical_sector;
	logic [7:0] volume_number;
	logic       address_ok;

	modport source (output valid, output kind, output data_byte, output byte_index,
		output track_number, output logical_sector, output volume_number,
		output address_ok, input ready);
	modport sink (input valid, input kind, input data_byte, input byte_index,
		input track_number, input logical_sector, input volume_number,
		input address_ok, output ready);
endinterface

interface gcrsnd_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] track_limit;

	modport source (output valid, output track_limit, input ready);
	modport sink (input valid, input track_limit, output ready);
endinterface

/* rtl/gcrsnd_cell.sv */
// One 6-bit cell of the secondary value chain.
// Depends on nothing.
module gcrsnd_cell (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       shift,
	input  logic [5:0] d,
	output logic [5:0] q
);

	logic [5:0] val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			val_q <= '0;
		end else if (shift) begin
			val_q <= d;
		end
	end

	assign q = val_q;

endmodule

/* rtl/gcrsnd_chain.sv */
// Chain of secondary value cells: filled at the tail, read and rotated at the head.
// Depends on gcrsnd_pkg and gcrsnd_cell.
module gcrsnd_chain (
	input  logic                   clk,
	input  logic                   arst_n,
	input  gcrsnd_pkg::chain_ctl_t ctl,
	input  logic [5:0]             din,
	output logic [5:0]             head
);

	logic [5:0] cell_q [gcrsnd_pkg::SecondaryCount];
	logic [5:0] tail_d;

	// during the byte phase the head wraps to the tail so entries come back in order
	assign tail_d = ctl.fill ? din : cell_q[0];

	for (genvar k = 0; k < gcrsnd_pkg::SecondaryCount; k++) begin : g_cell
		logic [5:0] d;
		if (k == gcrsnd_pkg::SecondaryCount - 1) begin : g_tail
			assign d = tail_d;
		end else begin : g_mid
			assign d = cell_q[k + 1];
		end
		gcrsnd_cell u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.shift (ctl.shift),
			.d     (d),
			.q     (cell_q[k])
		);
	end

	assign head = cell_q[0];

endmodule

/* rtl/gcrsnd_top_note.sv */
// Parse sequencer of the GCR sector nibble decoder: prolog and epilog matching,
// address field decode and the data nibble un-translation.
// Depends on gcrsnd_pkg and gcrsnd_chain.
module gcrsnd_seq (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,          // a nibble request is accepted this cycle
	input  logic [7:0] nb,
	input  logic [7:0] track_limit,
	output logic       emit,
	output logic [1:0] kind,
	output logic [7:0] data_byte,
	output logic [7:0] byte_index,
	output logic [7:0] track_number,
	output logic [3:0] logical_sector,
	output logic [7:0] volume_number,
	output logic       address_ok
);

	gcrsnd_pkg::phase_t      phase_q, phase_d;
	logic [7:0]              first_half_q, first_half_d;
	logic [7:0]              volume_q, volume_d;
	logic [7:0]              track_q, track_d;
	logic [7:0]              sector_q, sector_d;
	logic [5:0]              xor_q, xor_d;
	logic [8:0]              count_q, count_d;
	gcrsnd_pkg::gcr_lookup_t lk;
	logic [5:0]              xor_n;
	logic [5:0]              head;
	logic [7:0]              idx;
	gcrsnd_pkg::chain_ctl_t  ctl;
	gcrsnd_pkg::phase_t      scan_a_next;
	gcrsnd_pkg::phase_t      scan_d_next;
	logic                    in_fill;
	logic                    in_bytes;
	gcrsnd_pkg::kind_t       kind_c;
	logic [1:0]              pair;

	assign lk       = gcrsnd_pkg::gcr_lookup(nb);
	assign xor_n    = xor_q ^ lk.value;
	assign in_fill  = count_q < 9'(gcrsnd_pkg::SecondaryCount);
	assign in_bytes = count_q < 9'(gcrsnd_pkg::SectorNibbles);
	assign idx      = 8'(count_q - 9'(gcrsnd_pkg::SecondaryCount));

	// a mismatch re-checks the same nibble in the scan phase
	assign scan_a_next = (nb == gcrsnd_pkg::MarkD5) ? gcrsnd_pkg::PhA2 : gcrsnd_pkg::PhScanA;
	assign scan_d_next = (nb == gcrsnd_pkg::MarkD5) ? gcrsnd_pkg::PhD2 : gcrsnd_pkg::PhScanD;

	// next state
	always_comb begin
		phase_d      = phase_q;
		first_half_d = first_half_q;
		volume_d     = volume_q;
		track_d      = track_q;
		sector_d     = sector_q;
		xor_d        = xor_q;
		count_d      = count_q;
		unique case (phase_q)
			gcrsnd_pkg::PhA2: begin
				phase_d = (nb == gcrsnd_pkg::MarkAA) ? gcrsnd_pkg::PhA3 : scan_a_next;
			end
			gcrsnd_pkg::PhA3: begin
				phase_d = (nb == gcrsnd_pkg::Mark96) ? gcrsnd_pkg::PhVolH : scan_a_next;
			end
			gcrsnd_pkg::PhVolH: begin
				first_half_d = nb;
				phase_d      = gcrsnd_pkg::PhVolL;
			end
			gcrsnd_pkg::PhTrkH: begin
				first_half_d = nb;
				phase_d      = gcrsnd_pkg::PhTrkL;
			end
			gcrsnd_pkg::PhSecH: begin
				first_half_d = nb;
				phase_d      = gcrsnd_pkg::PhSecL;
			end
			gcrsnd_pkg::PhCkH: begin
				first_half_d = nb;
				phase_d      = gcrsnd_pkg::PhCkL;
			end
			gcrsnd_pkg::PhVolL: begin
				volume_d = gcrsnd_pkg::pair_decode(first_half_q, nb);
				phase_d  = gcrsnd_pkg::PhTrkH;
			end
			gcrsnd_pkg::PhTrkL: begin
				track_d = gcrsnd_pkg::pair_decode(first_half_q, nb);
				phase_d = gcrsnd_pkg::PhSecH;
			end
			gcrsnd_pkg::PhSecL: begin
				sector_d = gcrsnd_pkg::pair_decode(first_half_q, nb);
				phase_d  = gcrsnd_pkg::PhCkH;
			end
			gcrsnd_pkg::PhCkL: begin
				phase_d = gcrsnd_pkg::PhAep1;
			end
			gcrsnd_pkg::PhAep1: begin
				phase_d = (nb == gcrsnd_pkg::MarkDE) ? gcrsnd_pkg::PhAep2 : scan_a_next;
			end
			gcrsnd_pkg::PhAep2: begin
				phase_d = (nb == gcrsnd_pkg::MarkAA) ? gcrsnd_pkg::PhScanD : scan_a_next;
			end
			gcrsnd_pkg::PhScanD: begin
				phase_d = scan_d_next;
			end
			gcrsnd_pkg::PhD2: begin
				phase_d = (nb == gcrsnd_pkg::MarkAA) ? gcrsnd_pkg::PhD3 : scan_d_next;
			end
			gcrsnd_pkg::PhD3: begin
				if (nb == gcrsnd_pkg::MarkAD) begin
					phase_d = gcrsnd_pkg::PhData;
					xor_d   = '0;
					count_d = '0;
				end else begin
					phase_d = scan_d_next;
				end
			end
			gcrsnd_pkg::PhData: begin
				if (!lk.hit) begin
					phase_d = scan_a_next;
				end else begin
					xor_d   = xor_n;
					count_d = count_q + 9'd1;
					if (!in_bytes) begin
						phase_d = gcrsnd_pkg::PhScanE;
					end
				end
			end
			gcrsnd_pkg::PhScanE: begin
				phase_d = (nb == gcrsnd_pkg::MarkDE) ? gcrsnd_pkg::PhE2 : gcrsnd_pkg::PhScanE;
			end
			gcrsnd_pkg::PhE2: begin
				phase_d = (nb == gcrsnd_pkg::MarkAA) ? gcrsnd_pkg::PhE3 : scan_a_next;
			end
			gcrsnd_pkg::PhE3: begin
				phase_d = (nb == gcrsnd_pkg::MarkEB) ? gcrsnd_pkg::PhScanA : scan_a_next;
			end
			default: begin
				phase_d = scan_a_next;
			end
		endcase
	end

	// result and chain control
	always_comb begin
		emit   = 1'b0;
		kind_c = gcrsnd_pkg::KindData;
		ctl    = '0;
		if (phase_q == gcrsnd_pkg::PhData) begin
			if (!lk.hit) begin
				emit   = 1'b1;
				kind_c = gcrsnd_pkg::KindAbort;
			end else if (in_fill) begin
				ctl.shift = 1'b1;
				ctl.fill  = 1'b1;
			end else if (in_bytes) begin
				emit      = 1'b1;
				ctl.shift = 1'b1;
			end else begin
				emit   = 1'b1;
				kind_c = (xor_n == 6'd0) ? gcrsnd_pkg::KindSectorOk : gcrsnd_pkg::KindCkBad;
			end
		end
		ctl.shift = ctl.shift & take;
	end

	// secondary bit pair for this byte, swapped; group picks which pair of the entry
	always_comb begin
		if (idx < 8'(gcrsnd_pkg::SecondaryCount)) begin
			pair = {head[0], head[1]};
		end else if (idx < 8'(2 * gcrsnd_pkg::SecondaryCount)) begin
			pair = {head[2], head[3]};
		end else begin
			pair = {head[4], head[5]};
		end
	end

	assign kind           = kind_c;
	assign data_byte      = (kind_c == gcrsnd_pkg::KindData) ? {xor_n, pair} : 8'd0;
	assign byte_index     = (kind_c == gcrsnd_pkg::KindData) ? idx : 8'd0;
	assign track_number   = track_q;
	assign volume_number  = volume_q;
	assign logical_sector = (sector_q[7:4] == 4'd0) ? gcrsnd_pkg::SectorMap[sector_q[3:0]] : 4'd0;
	assign address_ok     = (sector_q[7:4] == 4'd0) && (track_q < track_limit);

	gcrsnd_chain u_chain (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ctl),
		.din   (xor_n),
		.head  (head)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= gcrsnd_pkg::PhScanA;
			first_half_q <= '0;
			volume_q     <= '0;
			track_q      <= '0;
			sector_q     <= '0;
			xor_q        <= '0;
			count_q      <= '0;
		end else if (take) begin
			phase_q      <= phase_d;
			first_half_q <= first_half_d;
			volume_q     <= volume_d;
			track_q      <= track_d;
			sector_q     <= sector_d;
			xor_q        <= xor_d;
			count_q      <= count_d;
		end
	end

endmodule

/* rtl/gcr_sector_nibble_decoder_unit.sv */
// GCR sector nibble decoder, top level: one raw disk nibble per request in, at
// most one result per nibble out. A nibble is taken in every cycle that the
// channel is not held off; its result appears in the output register in the
// cycle after it is taken. The nibble channel is held off only while
// the output register holds a result that is not being taken. The 86 secondary
// values of a sector sit in a row of 86 cells that shift one place per data
// nibble: filled at the tail, then read at the head and wrapped around for the
// 256 data bytes. No clearing pass after reset. The track limit register may be
// written at any time and is always ready; write it only while the decoder is idle.
// Depends on gcrsnd_pkg, gcrsnd_if and gcrsnd_seq.
module gcr_sector_nibble_decoder_unit (
	input logic         clk,
	input logic         arst_n,
	gcrsnd_nib_if.sink   nib,
	gcrsnd_res_if.source res,
	gcrsnd_cfg_if.sink   cfg
);

	logic       take;
	logic       emit;
	logic [1:0] kind_c;
	logic [7:0] data_byte_c;
	logic [7:0] byte_index_c;
	logic [7:0] track_c;
	logic [3:0] sector_c;
	logic [7:0] volume_c;
	logic       addr_ok_c;
	logic [7:0] track_limit_q;

	logic       res_valid_q;
	logic [1:0] kind_q;
	logic [7:0] data_byte_q;
	logic [7:0] byte_index_q;
	logic [7:0] track_q;
	logic [3:0] sector_q;
	logic [7:0] volume_q;
	logic       addr_ok_q;

	assign nib.ready = !res_valid_q || res.ready;
	assign take      = nib.valid && nib.ready;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			track_limit_q <= gcrsnd_pkg::TrackLimitReset;
		end else if (cfg.valid) begin
			track_limit_q <= cfg.track_limit;
		end
	end

	gcrsnd_seq u_seq (
		.clk           (clk),
		.arst_n        (arst_n),
		.take          (take),
		.nb            (nib.nibble),
		.track_limit   (track_limit_q),
		.emit          (emit),
		.kind          (kind_c),
		.data_byte     (data_byte_c),
		.byte_index    (byte_index_c),
		.track_number  (track_c),
		.logical_sector(sector_c),
		.volume_number (volume_c),
		.address_ok    (addr_ok_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (take) begin
			res_valid_q <= emit;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) begin
			kind_q       <= kind_c;
			data_byte_q  <= data_byte_c;
			byte_index_q <= byte_index_c;
			track_q      <= track_c;
			sector_q     <= sector_c;
			volume_q     <= volume_c;
			addr_ok_q    <= addr_ok_c;
		end
	end

	assign res.valid          = res_valid_q;
	assign res.kind           = kind_q;
	assign res.data_byte      = data_byte_q;
	assign res.byte_index     = byte_index_q;
	assign res.track_number   = track_q;
	assign res.logical_sector = sector_q;
	assign res.volume_number  = volume_q;
	assign res.address_ok     = addr_ok_q;

endmodule

/* verif/gcr_sector_nibble_decoder_unit_tb.sv */
`timescale 1ns / 100ps
// Self-checking bench for gcr_sector_nibble_decoder_unit: framed and broken sectors
// against an in-bench decoder model. Depends on gcrsnd_pkg, gcrsnd_if and the RTL.
module gcr_sector_nibble_decoder_unit_tb;

	localparam int CycleLimit = 500000;
	localparam int PhaseNibbles = 200;
	localparam int SettleCycles = 4;

	// 6-bit value -> disk nibble
	localparam logic [7:0] DiskCodes [64] = '{
		8'h96, 8'h97, 8'h9a, 8'h9b, 8'h9d, 8'h9e, 8'h9f, 8'ha6,
		8'ha7, 8'hab, 8'hac, 8'had, 8'hae, 8'haf, 8'hb2, 8'hb3,
		8'hb4, 8'hb5, 8'hb6, 8'hb7, 8'hb9, 8'hba, 8'hbb, 8'hbc,
		8'hbd, 8'hbe, 8'hbf, 8'hcb, 8'hcd, 8'hce, 8'hcf, 8'hd3,
		8'hd6, 8'hd7, 8'hd9, 8'hda, 8'hdb, 8'hdc, 8'hdd, 8'hde,
		8'hdf, 8'he5, 8'he6, 8'he7, 8'he9, 8'hea, 8'heb, 8'hec,
		8'hed, 8'hee, 8'hef, 8'hf2, 8'hf3, 8'hf4, 8'hf5, 8'hf6,
		8'hf7, 8'hf9, 8'hfa, 8'hfb, 8'hfc, 8'hfd, 8'hfe, 8'hff
	};

	localparam logic [3:0] Interleave [16] = '{
		4'h0, 4'h7, 4'hE, 4'h6, 4'hD, 4'h5, 4'hC, 4'h4,
		4'hB, 4'h3, 4'hA, 4'h2, 4'h9, 4'h1, 4'h8, 4'hF
	};

	typedef struct packed {
		gcrsnd_pkg::kind_t kind;
		logic [7:0]        data_byte;
		logic [7:0]        byte_index;
		logic [7:0]        track_number;
		logic [3:0]        logical_sector;
		logic [7:0]        volume_number;
		logic              address_ok;
	} sector_result_t;

	class nibble_stream_scoreboard;
		gcrsnd_pkg::phase_t phase;
		logic [7:0]         first_half;
		logic [7:0]         volume;
		logic [7:0]         track;
		logic [7:0]         sector;
		logic [7:0]         track_limit;
		logic [5:0]         running_xor;
		logic [8:0]         nibble_count;
		logic [5:0]         secondary [gcrsnd_pkg::SecondaryCount];
		sector_result_t     decoded_due [$];
		int                 mismatch_count;
		int                 checked_count;

		function new();
			phase = gcrsnd_pkg::PhScanA;
			first_half = '0;
			volume = '0;
			track = '0;
			sector = '0;
			track_limit = gcrsnd_pkg::TrackLimitReset;
			running_xor = '0;
			nibble_count = '0;
			mismatch_count = 0;
			checked_count = 0;
		endfunction

		function int code_value(logic [7:0] nb);
			for (int k = 0; k < 64; k++)
				if (DiskCodes[k] == nb)
					return k;
			return -1;
		endfunction

		function logic [7:0] join_halves(logic [7:0] hi, logic [7:0] lo);
			return ({hi[6:0], 1'b0} & 8'hAA) | (lo & 8'h55);
		endfunction

		function void queue_result(gcrsnd_pkg::kind_t kind, logic [7:0] data,
			logic [7:0] idx);
			sector_result_t r;
			r.kind = kind;
			r.data_byte = data;
			r.byte_index = idx;
			r.track_number = track;
			r.logical_sector = (sector < 16) ? Interleave[sector[3:0]] : 4'd0;
			r.volume_number = volume;
			r.address_ok = (sector < 16) && (track < track_limit);
			decoded_due.push_back(r);
		endfunction

		// one accepted nibble; a failed mark match re-checks the nibble once
		function void take_nibble(logic [7:0] nb);
			bit         again;
			int         v;
			int         idx;
			int         sh;
			logic [5:0] low_pair;
			for (int pass = 0; pass < 2; pass++) begin
				again = 1'b0;
				case (phase)
					gcrsnd_pkg::PhA2: begin
						if (nb == gcrsnd_pkg::MarkAA) phase = gcrsnd_pkg::PhA3;
						else begin
							phase = gcrsnd_pkg::PhScanA;
							again = 1'b1;
						end
					end
					gcrsnd_pkg::PhA3: begin
						if (nb == gcrsnd_pkg::Mark96) phase = gcrsnd_pkg::PhVolH;
						else begin
							phase = gcrsnd_pkg::PhScanA;
							again = 1'b1;
						end
					end
					gcrsnd_pkg::PhVolH, gcrsnd_pkg::PhTrkH,
					gcrsnd_pkg::PhSecH, gcrsnd_pkg::PhCkH: begin
						first_half = nb;
						phase = gcrsnd_pkg::phase_t'(phase + 5'd1);
					end
					gcrsnd_pkg::PhVolL: begin
						volume = join_halves(first_half, nb);
						phase = gcrsnd_pkg::PhTrkH;
					end
					gcrsnd_pkg::PhTrkL: begin
						track = join_halves(first_half, nb);
						phase = gcrsnd_pkg::PhSecH;
					end
					gcrsnd_pkg::PhSecL: begin
						sector = join_halves(first_half, nb);
						phase = gcrsnd_pkg::PhCkH;
					end
					gcrsnd_pkg::PhCkL: phase = gcrsnd_pkg::PhAep1;
					gcrsnd_pkg::PhAep1: begin
						if (nb == gcrsnd_pkg::MarkDE) phase = gcrsnd_pkg::PhAep2;
						else begin
							phase = gcrsnd_pkg::PhScanA;
							again = 1'b1;
						end
					end
					gcrsnd_pkg::PhAep2: begin
						if (nb == gcrsnd_pkg::MarkAA) phase = gcrsnd_pkg::PhScanD;
						else begin
							phase = gcrsnd_pkg::PhScanA;
							again = 1'b1;
						end
					end
					gcrsnd_pkg::PhScanD: begin
						if (nb == gcrsnd_pkg::MarkD5) phase = gcrsnd_pkg::PhD2;
					end
					gcrsnd_pkg::PhD2: begin
						if (nb == gcrsnd_pkg::MarkAA) phase = gcrsnd_pkg::PhD3;
						else begin
							phase = gcrsnd_pkg::PhScanD;
							again = 1'b1;
						end
					end
					gcrsnd_pkg::PhD3: begin
						if (nb == gcrsnd_pkg::MarkAD) begin
							phase = gcrsnd_pkg::PhData;
							running_xor = '0;
							nibble_count = '0;
						end else begin
							phase = gcrsnd_pkg::PhScanD;
							again = 1'b1;
						end
					end
					gcrsnd_pkg::PhData: begin
						v = code_value(nb);
						if (v < 0) begin
							queue_result(gcrsnd_pkg::KindAbort, 8'd0, 8'd0);
							phase = gcrsnd_pkg::PhScanA;
							again = 1'b1;
						end else begin
							running_xor = running_xor ^ 6'(v);
							if (nibble_count < gcrsnd_pkg::SecondaryCount) begin
								secondary[nibble_count] = running_xor;
							end else if (nibble_count < gcrsnd_pkg::SectorNibbles) begin
								idx = int'(nibble_count) - gcrsnd_pkg::SecondaryCount;
								low_pair = secondary[idx % gcrsnd_pkg::SecondaryCount];
								sh = (idx / gcrsnd_pkg::SecondaryCount) * 2;
								// low bit pair goes in swapped
								queue_result(gcrsnd_pkg::KindData,
									{running_xor, low_pair[sh], low_pair[sh + 1]}, 8'(idx));
							end else begin
								queue_result((running_xor == 6'd0) ?
									gcrsnd_pkg::KindSectorOk : gcrsnd_pkg::KindCkBad,
									8'd0, 8'd0);
								phase = gcrsnd_pkg::PhScanE;
							end
							nibble_count = nibble_count + 9'd1;
						end
					end
					gcrsnd_pkg::PhScanE: begin
						if (nb == gcrsnd_pkg::MarkDE) phase = gcrsnd_pkg::PhE2;
					end
					gcrsnd_pkg::PhE2: begin
						if (nb == gcrsnd_pkg::MarkAA) phase = gcrsnd_pkg::PhE3;
						else begin
							phase = gcrsnd_pkg::PhScanA;
							again = 1'b1;
						end
					end
					gcrsnd_pkg::PhE3: begin
						phase = gcrsnd_pkg::PhScanA;
						if (nb != gcrsnd_pkg::MarkEB) again = 1'b1;
					end
					default: begin
						phase = (nb == gcrsnd_pkg::MarkD5) ?
							gcrsnd_pkg::PhA2 : gcrsnd_pkg::PhScanA;
					end
				endcase
				if (!again)
					break;
			end
		endfunction

		task report_mismatch(string msg);
			mismatch_count++;
			$display("ERROR @%0t: %s", $realtime, msg);
		endtask

		task check_result(sector_result_t got);
			sector_result_t want;
			checked_count++;
			if (decoded_due.size() == 0) begin
				report_mismatch($sformatf("result %0d kind %0d with nothing pending",
					checked_count, got.kind));
				return;
			end
			want = decoded_due.pop_front();
			if (got.kind !== want.kind)
				report_mismatch($sformatf("result %0d kind %0d, want %0d",
					checked_count, got.kind, want.kind));
			if (got.data_byte !== want.data_byte)
				report_mismatch($sformatf("result %0d data_byte %h, want %h",
					checked_count, got.data_byte, want.data_byte));
			if (got.byte_index !== want.byte_index)
				report_mismatch($sformatf("result %0d byte_index %0d, want %0d",
					checked_count, got.byte_index, want.byte_index));
			if (got.track_number !== want.track_number)
				report_mismatch($sformatf("result %0d track_number %0d, want %0d",
					checked_count, got.track_number, want.track_number));
			if (got.logical_sector !== want.logical_sector)
				report_mismatch($sformatf("result %0d logical_sector %0d, want %0d",
					checked_count, got.logical_sector, want.logical_sector));
			if (got.volume_number !== want.volume_number)
				report_mismatch($sformatf("result %0d volume_number %0d, want %0d",
					checked_count, got.volume_number, want.volume_number));
			if (got.address_ok !== want.address_ok)
				report_mismatch($sformatf("result %0d address_ok %b, want %b",
					checked_count, got.address_ok, want.address_ok));
		endtask
	endclass

	logic clk;
	logic arst_n;

	gcrsnd_nib_if nib_ch ();
	gcrsnd_res_if res_ch ();
	gcrsnd_cfg_if cfg_ch ();

	gcr_sector_nibble_decoder_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.nib    (nib_ch),
		.res    (res_ch),
		.cfg    (cfg_ch)
	);

	nibble_stream_scoreboard stream_board = new();

	int          cycle_count = 0;
	int          nibbles_sent = 0;
	int          sectors_sent = 0;
	int          limits_written = 0;
	int          burst_left = 0;
	int          stall_tick = 0;
	logic [15:0] stall_pattern = 16'hFFFF;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("timeout after %0d cycles, %0d results pending",
				cycle_count, stream_board.decoded_due.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	// receiver stalls: ready follows a repeating 16-bit pattern that is redrawn periodically, often none at all
	always @(negedge clk) begin
		stall_tick++;
		if (stall_tick % 128 == 0)
			stall_pattern = ($urandom_range(3) == 0) ? 16'hFFFF : (16'($urandom) | 16'h0001);
		res_ch.ready <= stall_pattern[stall_tick % 16];
	end

	always @(posedge clk) begin
		sector_result_t got;
		if (arst_n && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
			got.kind = gcrsnd_pkg::kind_t'(res_ch.kind);
			got.data_byte = res_ch.data_byte;
			got.byte_index = res_ch.byte_index;
			got.track_number = res_ch.track_number;
			got.logical_sector = res_ch.logical_sector;
			got.volume_number = res_ch.volume_number;
			got.address_ok = res_ch.address_ok;
			stream_board.check_result(got);
		end
	end

	// called at a falling edge, returns at a falling edge
	task automatic send_nibble(input logic [7:0] nb);
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(4) == 0) ? $urandom_range(200, 600) : $urandom_range(1, 24);
			gap = ($urandom_range(4) == 0) ? 0 : $urandom_range(1, 10);
			if (gap != 0) begin
				nib_ch.valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		nib_ch.valid <= 1'b1;
		nib_ch.nibble <= nb;
		do @(posedge clk); while (nib_ch.ready !== 1'b1);
		stream_board.take_nibble(nb);
		nibbles_sent++;
		@(negedge clk);
	endtask

	task automatic send_pair(input logic [7:0] v);
		send_nibble((v >> 1) | 8'hAA);
		send_nibble(v | 8'hAA);
	endtask

	task automatic send_noise(input int count);
		repeat (count) send_nibble(8'($urandom));
	endtask

	function automatic logic [7:0] pick_bad_nibble();
		logic [7:0] nb;
		do nb = 8'($urandom); while (stream_board.code_value(nb) >= 0);
		return nb;
	endfunction

	// one sector, mostly well formed; broken framing or a bad data nibble ends it early
	task automatic send_sector();
		logic [7:0] payload [gcrsnd_pkg::SectorBytes];
		logic [5:0] level [gcrsnd_pkg::SectorNibbles];
		logic [5:0] prev;
		logic [7:0] vol;
		logic [7:0] trk;
		logic [7:0] sec;
		logic [7:0] nb;
		int         style;
		int         bad_at;
		int         i;
		sectors_sent++;
		vol = 8'($urandom);
		case ($urandom_range(3))
			0: trk = 8'($urandom);
			1: trk = stream_board.track_limit - 8'($urandom_range(1));
			default: trk = 8'($urandom_range(40));
		endcase
		sec = ($urandom_range(7) == 0) ? 8'($urandom) : 8'($urandom_range(15));

		repeat ($urandom_range(6)) send_nibble(8'hFF);
		case ($urandom_range(11))
			0: send_nibble(gcrsnd_pkg::MarkD5);
			1: begin
				send_nibble(gcrsnd_pkg::MarkD5);
				send_nibble(gcrsnd_pkg::MarkAA);
			end
			default: ;
		endcase
		send_nibble(gcrsnd_pkg::MarkD5);
		send_nibble(gcrsnd_pkg::MarkAA);
		send_nibble(gcrsnd_pkg::Mark96);
		if ($urandom_range(9) == 0) begin
			repeat (8) send_nibble(8'($urandom));
		end else begin
			send_pair(vol);
			send_pair(trk);
			send_pair(sec);
			send_pair(vol ^ trk ^ sec);
		end
		if ($urandom_range(11) == 0) begin
			if ($urandom_range(1)) send_nibble(gcrsnd_pkg::MarkDE);
			do nb = 8'($urandom);
			while (nb == gcrsnd_pkg::MarkAA || nb == gcrsnd_pkg::MarkDE);
			send_nibble(nb);
			return;
		end
		send_nibble(gcrsnd_pkg::MarkDE);
		send_nibble(gcrsnd_pkg::MarkAA);
		send_nibble(gcrsnd_pkg::MarkEB);
		repeat ($urandom_range(6)) send_nibble(8'hFF);
		case ($urandom_range(9))
			0: begin
				send_nibble(gcrsnd_pkg::MarkD5);
				send_nibble(gcrsnd_pkg::MarkAA);
			end
			1: begin
				send_nibble(gcrsnd_pkg::MarkD5);
				send_nibble(8'hFF);
			end
			default: ;
		endcase
		send_nibble(gcrsnd_pkg::MarkD5);
		send_nibble(gcrsnd_pkg::MarkAA);
		send_nibble(gcrsnd_pkg::MarkAD);

		style = $urandom_range(5);
		for (i = 0; i < gcrsnd_pkg::SectorBytes; i++) begin
			case (style)
				0: payload[i] = 8'h00;
				1: payload[i] = 8'hFF;
				2: payload[i] = 8'(i);
				default: payload[i] = 8'($urandom);
			endcase
		end
		// secondary values carry the low pairs of bytes j, j+86, j+172, swapped
		for (int j = 0; j < gcrsnd_pkg::SecondaryCount; j++) begin
			level[j] = 6'($urandom);
			for (int t = 0; t < 3; t++) begin
				i = j + gcrsnd_pkg::SecondaryCount * t;
				if (i < gcrsnd_pkg::SectorBytes) begin
					level[j][2 * t] = payload[i][1];
					level[j][2 * t + 1] = payload[i][0];
				end
			end
		end
		for (i = 0; i < gcrsnd_pkg::SectorBytes; i++)
			level[gcrsnd_pkg::SecondaryCount + i] = payload[i][7:2];

		bad_at = ($urandom_range(9) == 0) ? $urandom_range(gcrsnd_pkg::SectorNibbles) : -1;
		prev = '0;
		for (i = 0; i < gcrsnd_pkg::SectorNibbles; i++) begin
			if (i == bad_at) begin
				send_nibble(pick_bad_nibble());
				return;
			end
			send_nibble(DiskCodes[level[i] ^ prev]);
			prev = level[i];
		end
		if (bad_at == gcrsnd_pkg::SectorNibbles) begin
			send_nibble(pick_bad_nibble());
			return;
		end
		// checksum nibble brings the running XOR to zero unless spoiled
		if ($urandom_range(7) == 0)
			send_nibble(DiskCodes[prev ^ 6'($urandom_range(1, 63))]);
		else
			send_nibble(DiskCodes[prev]);

		repeat ($urandom_range(3)) send_nibble(8'($urandom));
		case ($urandom_range(9))
			0: begin
				send_nibble(gcrsnd_pkg::MarkDE);
				send_nibble(gcrsnd_pkg::MarkAA);
				send_nibble(8'($urandom));
			end
			1: begin
				send_nibble(gcrsnd_pkg::MarkDE);
				send_nibble(8'($urandom));
			end
			default: begin
				send_nibble(gcrsnd_pkg::MarkDE);
				send_nibble(gcrsnd_pkg::MarkAA);
				send_nibble(gcrsnd_pkg::MarkEB);
			end
		endcase
	endtask

	// no new request until every pending result is back and the pipe has settled
	task automatic drain();
		nib_ch.valid <= 1'b0;
		burst_left = 0;
		while (stream_board.decoded_due.size() != 0) @(negedge clk);
		repeat (SettleCycles) @(negedge clk);
	endtask

	task automatic write_track_limit(input logic [7:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.track_limit <= value;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		stream_board.track_limit = value;
		limits_written++;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	initial begin
		logic [7:0] opening [22];
		int         phase_start;
		arst_n = 1'b0;
		nib_ch.valid = 1'b0;
		nib_ch.nibble = 8'h00;
		cfg_ch.valid = 1'b0;
		cfg_ch.track_limit = 8'h00;
		res_ch.ready = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// field extremes, prolog re-check, data prolog fallback, then an abort on 00
		opening = '{8'h00, 8'hFF, gcrsnd_pkg::MarkD5, gcrsnd_pkg::MarkD5,
			gcrsnd_pkg::MarkAA, gcrsnd_pkg::Mark96,
			8'hFF, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h00, 8'h00, 8'h00,
			gcrsnd_pkg::MarkDE, gcrsnd_pkg::MarkAA, gcrsnd_pkg::MarkD5, gcrsnd_pkg::MarkAA,
			gcrsnd_pkg::MarkD5, gcrsnd_pkg::MarkAA, gcrsnd_pkg::MarkAD, 8'h00};
		foreach (opening[k])
			send_nibble(opening[k]);

		for (int p = 0; p < 5; p++) begin
			if (p != 0) begin
				drain();
				case (p)
					1: write_track_limit(8'd255);
					2: write_track_limit(8'd0);
					3: write_track_limit(8'd1);
					default: write_track_limit(8'($urandom_range(2, 254)));
				endcase
			end
			phase_start = nibbles_sent;
			while (nibbles_sent - phase_start < PhaseNibbles) begin
				if ($urandom_range(6) == 0)
					send_noise($urandom_range(1, 40));
				else
					send_sector();
			end
		end
		drain();

		if (stream_board.decoded_due.size() != 0)
			stream_board.report_mismatch($sformatf("%0d results never arrived",
				stream_board.decoded_due.size()));
		$display("%0d nibbles over %0d sector attempts, %0d track limit writes",
			nibbles_sent, sectors_sent, limits_written);
		$display("%0d results checked, %0d mismatches",
			stream_board.checked_count, stream_board.mismatch_count);
		if (stream_board.mismatch_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
